/* rtl/abt_pkg.sv */
`timescale 1ns / 1ps

package abt_pkg;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;
  localparam q_t Q_ONE = 32'sh00010000;

  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_SCALE_XX = 3'd0;
  localparam cfg_idx_t CFG_MIX_XY   = 3'd1;
  localparam cfg_idx_t CFG_SHIFT_X  = 3'd2;
  localparam cfg_idx_t CFG_MIX_YX   = 3'd3;
  localparam cfg_idx_t CFG_SCALE_YY = 3'd4;
  localparam cfg_idx_t CFG_SHIFT_Y  = 3'd5;

  typedef struct packed {
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } box_t;

  typedef struct packed {
    logic signed [31:0] out_min_x;
    logic signed [31:0] out_min_y;
    logic signed [31:0] out_max_x;
    logic signed [31:0] out_max_y;
  } bound_t;

  typedef struct packed {
    logic signed [31:0] scale_xx;
    logic signed [31:0] mix_xy;
    logic signed [31:0] shift_x;
    logic signed [31:0] mix_yx;
    logic signed [31:0] scale_yy;
    logic signed [31:0] shift_y;
  } coef_t;

  // saturated Q16.16 products; index 0 = min corner coordinate, 1 = max
  typedef struct packed {
    q_t [1:0] ax;
    q_t [1:0] by;
    q_t [1:0] cx;
    q_t [1:0] dy;
  } prods_t;

  // mapped corners: 0 (min,min), 1 (max,min), 2 (max,max), 3 (min,max)
  typedef struct packed {
    q_t [3:0] nx;
    q_t [3:0] ny;
  } pts_t;

  function automatic q_t sat_prod(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p >>> 16;
    if (s > 64'sd2147483647) begin
      return Q_MAX;
    end else if (s < -64'sd2147483648) begin
      return Q_MIN;
    end
    return s[31:0];
  endfunction

  function automatic q_t sat_add(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

endpackage

/* rtl/abt_mul.sv */
`timescale 1ns / 1ps

module abt_mul (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  abt_pkg::box_t  box,
  input  abt_pkg::coef_t coef,
  output logic           out_valid,
  output abt_pkg::prods_t prods
);
  import abt_pkg::*;

  logic signed [1:0][63:0] p_ax, p_by, p_cx, p_dy;
  logic                    v1;

  always_ff @(posedge clk) begin
    p_ax[0] <= 64'(coef.scale_xx) * 64'(box.box_min_x);
    p_ax[1] <= 64'(coef.scale_xx) * 64'(box.box_max_x);
    p_by[0] <= 64'(coef.mix_xy) * 64'(box.box_min_y);
    p_by[1] <= 64'(coef.mix_xy) * 64'(box.box_max_y);
    p_cx[0] <= 64'(coef.mix_yx) * 64'(box.box_min_x);
    p_cx[1] <= 64'(coef.mix_yx) * 64'(box.box_max_x);
    p_dy[0] <= 64'(coef.scale_yy) * 64'(box.box_min_y);
    p_dy[1] <= 64'(coef.scale_yy) * 64'(box.box_max_y);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      prods.ax[i] <= sat_prod($signed(p_ax[i]));
      prods.by[i] <= sat_prod($signed(p_by[i]));
      prods.cx[i] <= sat_prod($signed(p_cx[i]));
      prods.dy[i] <= sat_prod($signed(p_dy[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

/* rtl/abt_sum.sv */
`timescale 1ns / 1ps

module abt_sum (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  abt_pkg::prods_t prods,
  input  abt_pkg::coef_t  coef,
  output logic            out_valid,
  output abt_pkg::pts_t   pts
);
  import abt_pkg::*;

  localparam logic [3:0] X_SEL = 4'b0110;  // corners using max x
  localparam logic [3:0] Y_SEL = 4'b1100;  // corners using max y

  pts_t lin;
  logic v1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      lin.nx[i] <= sat_add(prods.ax[X_SEL[i]], prods.by[Y_SEL[i]]);
      lin.ny[i] <= sat_add(prods.cx[X_SEL[i]], prods.dy[Y_SEL[i]]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pts.nx[i] <= sat_add(lin.nx[i], coef.shift_x);
      pts.ny[i] <= sat_add(lin.ny[i], coef.shift_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

/* rtl/abt_minmax.sv */
`timescale 1ns / 1ps

module abt_minmax (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  abt_pkg::pts_t   pts,
  output logic            out_valid,
  output abt_pkg::bound_t bound
);
  import abt_pkg::*;

  q_t [1:0] lo_x, hi_x, lo_y, hi_y;
  logic     v1;

  function automatic q_t qmin(input q_t a, input q_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic q_t qmax(input q_t a, input q_t b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    for (int i = 0; i < 2; i++) begin
      lo_x[i] <= qmin(pts.nx[2*i], pts.nx[2*i+1]);
      hi_x[i] <= qmax(pts.nx[2*i], pts.nx[2*i+1]);
      lo_y[i] <= qmin(pts.ny[2*i], pts.ny[2*i+1]);
      hi_y[i] <= qmax(pts.ny[2*i], pts.ny[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    bound.out_min_x <= qmin(lo_x[0], lo_x[1]);
    bound.out_max_x <= qmax(hi_x[0], hi_x[1]);
    bound.out_min_y <= qmin(lo_y[0], lo_y[1]);
    bound.out_max_y <= qmax(hi_y[0], hi_y[1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

/* rtl/affine_box_transform_2d.sv */
`timescale 1ns / 1ps

// Maps an axis-aligned box through a Q16.16 2D affine transform and returns
// the bounding box of the four mapped corners. A request is taken every
// cycle (busy stays low); its result appears on result with done high
// for one cycle, in request order. Each request passes through the
// six-stage pipeline: multiply, product round/saturate, linear sum,
// translation, and two min/max levels. The receiver cannot stall the block.
// Products are floored and every product and sum saturates to 32 bits.
// Matrix registers may only be written while no request is in flight;
// writes to indexes past shift_y are ignored.

module affine_box_transform_2d (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  abt_pkg::box_t             box,
  output logic                      done,
  output abt_pkg::bound_t           result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  abt_pkg::cfg_idx_t         cfg_index,
  input  logic [31:0]               cfg_data
);
  import abt_pkg::*;

  coef_t  coef;
  prods_t prods;
  pts_t   pts;
  logic   mul_valid;
  logic   sum_valid;
  logic   accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.scale_xx <= Q_ONE;
      coef.mix_xy   <= '0;
      coef.shift_x  <= '0;
      coef.mix_yx   <= '0;
      coef.scale_yy <= Q_ONE;
      coef.shift_y  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE_XX: coef.scale_xx <= cfg_data;
        CFG_MIX_XY:   coef.mix_xy   <= cfg_data;
        CFG_SHIFT_X:  coef.shift_x  <= cfg_data;
        CFG_MIX_YX:   coef.mix_yx   <= cfg_data;
        CFG_SCALE_YY: coef.scale_yy <= cfg_data;
        CFG_SHIFT_Y:  coef.shift_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  abt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .box       (box),
    .coef      (coef),
    .out_valid (mul_valid),
    .prods     (prods)
  );

  abt_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .prods     (prods),
    .coef      (coef),
    .out_valid (sum_valid),
    .pts       (pts)
  );

  abt_minmax u_minmax (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .pts       (pts),
    .out_valid (done),
    .bound     (result)
  );

endmodule
